// ===== src/two_class_ticket_queue_macros.svh =====
// Assertion helpers for the checker file of the ticket queue.
`ifndef TWO_CLASS_TICKET_QUEUE_MACROS_SVH
`define TWO_CLASS_TICKET_QUEUE_MACROS_SVH

// Checked only while the block is out of reset.
`define TCTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define TCTQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/tctq_pkg.sv =====
package tctq_pkg;

  // Field widths of the channels.
  localparam int OP_W     = 3;
  localparam int TICKET_W = 11;

  // Each cell of the chain holds the bits of 32 consecutive tickets.
  localparam int CELL_BITS = 32;
  localparam int CB_W      = 5;

  // Position and count widths cover the largest supported capacity (65536).
  localparam int POS_W = 16;
  localparam int CNT_W = 17;

  localparam logic [OP_W-1:0] OP_ISSUE      = 3'd0;
  localparam logic [OP_W-1:0] OP_ISSUE_VIP  = 3'd1;
  localparam logic [OP_W-1:0] OP_CALL       = 3'd2;
  localparam logic [OP_W-1:0] OP_COUNT      = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT_UPTO = 3'd4;
  localparam logic [OP_W-1:0] OP_CANCEL     = 3'd5;
  localparam logic [OP_W-1:0] OP_RESET      = 3'd6;

  typedef enum logic [1:0] {
    SCAN_COUNT,
    SCAN_CALL,
    SCAN_CANCEL
  } scan_kind_t;

  // Token that walks down the cell chain, one cell per cycle.
  typedef struct packed {
    logic             valid;
    scan_kind_t       kind;
    logic [CNT_W-1:0] limit;
    logic [POS_W-1:0] target;
    logic [CNT_W-1:0] cnt;
    logic             vip_hit;
    logic [POS_W-1:0] vip_pos;
    logic             norm_hit;
    logic [POS_W-1:0] norm_pos;
    logic             hit;
    logic             hit_vip;
  } tok_t;

  // Write request broadcast to every cell.
  typedef struct packed {
    logic             set_en;
    logic             clr_en;
    logic             clr_all;
    logic [POS_W-1:0] pos;
    logic             vip;
  } wr_t;

  typedef struct packed {
    logic [TICKET_W-1:0] ticket;
    logic                is_vip;
    logic [TICKET_W-1:0] tally;
    logic                status;
  } res_t;

  localparam res_t RES_ERR = '{ticket: '0, is_vip: 1'b0, tally: '0, status: 1'b1};

  function automatic logic [CB_W:0] popcount(input logic [CELL_BITS-1:0] v);
    logic [CB_W:0] n;
    n = '0;
    for (int i = 0; i < CELL_BITS; i++) begin
      n = n + (CB_W+1)'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [CB_W-1:0] lowest_set(input logic [CELL_BITS-1:0] v);
    logic [CB_W-1:0] idx;
    idx = '0;
    for (int i = CELL_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = CB_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== src/tctq_in_if.sv =====
interface tctq_in_if import tctq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [TICKET_W-1:0] ticket_number;

  modport source (output valid, operation, ticket_number, input ready);
  modport sink (input valid, operation, ticket_number, output ready);
endinterface

// ===== src/tctq_out_if.sv =====
interface tctq_out_if import tctq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TICKET_W-1:0] ticket;
  logic                is_vip;
  logic [TICKET_W-1:0] tally;
  logic                status;

  modport source (output valid, ticket, is_vip, tally, status, input ready);
  modport sink (input valid, ticket, is_vip, tally, status, output ready);
endinterface

// ===== src/two_class_ticket_queue.sv =====
// Two-priority ticket queue.
// Input channel in_ch carries one operation per item: issue, issue vip, call,
// count, count up to, cancel and reset. Output channel out_ch returns one
// result item per operation, except reset, which returns nothing.
// Issue, and any operation that fails on its arguments alone, goes straight
// to ST_DONE: its result is held in pend_r, then moved to the output register,
// which frees in_ch. Call, count, count up to and a valid cancel send a scan
// token down a chain of CAPACITY/32 cells (rounded up), one cell of 32 tickets
// per cycle; the result is taken from the token at the chain's tail and then
// passes through ST_DONE to the output register in the same way.
// A reset operation clears all tickets when accepted; in_ch is ready again on
// the next cycle. rst_n does the same and also drops any pending result.
// The result sits in an output register, so in_ch takes the next item while
// the receiver stalls. A second finished result is held internally and
// in_ch stays low until the output register has been emptied.
module two_class_ticket_queue import tctq_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  tctq_in_if.sink     in_ch,
  tctq_out_if.source  out_ch
);

  localparam int NCELL = (CAPACITY + CELL_BITS - 1) / CELL_BITS;
  localparam int LW    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [LW-1:0] last_r, last_nxt;
  logic [LW-1:0] last_inc;
  res_t          pend_r, pend_nxt;
  res_t          out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;
  wr_t           wr;
  tok_t          head;
  tok_t          tail;
  tok_t          chain [NCELL+1];
  logic          num_bad;

  assign chain[0] = head;
  assign tail     = chain[NCELL];

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    tctq_cell #(
      .CELL_IDX(k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .wr_i  (wr),
      .tok_i (chain[k]),
      .tok_o (chain[k+1])
    );
  end

  assign last_inc = last_r + LW'(1);
  // Ticket zero and tickets above the last one issued cannot be waiting.
  assign num_bad  = (in_ch.ticket_number == '0) ||
                    (CNT_W'(in_ch.ticket_number) > CNT_W'(last_r));

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    wr            = '0;
    head          = '0;
    head.kind     = SCAN_COUNT;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          priority case (in_ch.operation)
            OP_ISSUE, OP_ISSUE_VIP: begin
              if (last_r == LW'(CAPACITY)) begin
                pend_nxt = RES_ERR;
              end else begin
                wr.set_en       = 1'b1;
                wr.pos          = POS_W'(last_r);
                wr.vip          = (in_ch.operation == OP_ISSUE_VIP);
                last_nxt        = last_inc;
                pend_nxt        = '0;
                pend_nxt.ticket = TICKET_W'(last_inc);
                pend_nxt.is_vip = (in_ch.operation == OP_ISSUE_VIP);
              end
              state_nxt = ST_DONE;
            end
            OP_CALL: begin
              head.valid = 1'b1;
              head.kind  = SCAN_CALL;
              state_nxt  = ST_SWEEP;
            end
            OP_COUNT: begin
              head.valid = 1'b1;
              head.kind  = SCAN_COUNT;
              head.limit = '1;
              state_nxt  = ST_SWEEP;
            end
            OP_COUNT_UPTO: begin
              head.valid = 1'b1;
              head.kind  = SCAN_COUNT;
              head.limit = CNT_W'(in_ch.ticket_number);
              state_nxt  = ST_SWEEP;
            end
            OP_CANCEL: begin
              if (num_bad) begin
                pend_nxt  = RES_ERR;
                state_nxt = ST_DONE;
              end else begin
                head.valid  = 1'b1;
                head.kind   = SCAN_CANCEL;
                head.target = POS_W'(in_ch.ticket_number - TICKET_W'(1));
                state_nxt   = ST_SWEEP;
              end
            end
            OP_RESET: begin
              wr.clr_all = 1'b1;
              last_nxt   = '0;
            end
            default: begin
              pend_nxt  = RES_ERR;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SWEEP: begin
        if (tail.valid) begin
          pend_nxt  = '0;
          state_nxt = ST_DONE;
          unique case (tail.kind)
            SCAN_COUNT: begin
              pend_nxt.tally = TICKET_W'(tail.cnt);
            end
            SCAN_CALL: begin
              if (tail.vip_hit) begin
                wr.clr_en       = 1'b1;
                wr.pos          = tail.vip_pos;
                pend_nxt.ticket = TICKET_W'(tail.vip_pos + POS_W'(1));
                pend_nxt.is_vip = 1'b1;
              end else if (tail.norm_hit) begin
                wr.clr_en       = 1'b1;
                wr.pos          = tail.norm_pos;
                pend_nxt.ticket = TICKET_W'(tail.norm_pos + POS_W'(1));
              end else begin
                pend_nxt = RES_ERR;
              end
            end
            SCAN_CANCEL: begin
              if (tail.hit) begin
                wr.clr_en       = 1'b1;
                wr.pos          = tail.target;
                pend_nxt.ticket = TICKET_W'(tail.target + POS_W'(1));
                pend_nxt.is_vip = tail.hit_vip;
              end else begin
                pend_nxt = RES_ERR;
              end
            end
            default: begin
              pend_nxt = RES_ERR;
            end
          endcase
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.ticket = out_r.ticket;
  assign out_ch.is_vip = out_r.is_vip;
  assign out_ch.tally  = out_r.tally;
  assign out_ch.status = out_r.status;

endmodule

// ===== src/tctq_cell.sv =====
module tctq_cell import tctq_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  wr_t  wr_i,
  input  tok_t tok_i,
  output tok_t tok_o
);

  localparam logic [POS_W-CB_W-1:0] MY_ID = (POS_W-CB_W)'(CELL_IDX);
  localparam logic [CNT_W:0] BASE_E = (CNT_W+1)'(CELL_IDX * CELL_BITS);
  localparam logic [CNT_W:0] TOP_E  = (CNT_W+1)'((CELL_IDX + 1) * CELL_BITS);

  logic [CELL_BITS-1:0] wait_r, wait_nxt;
  logic [CELL_BITS-1:0] vip_r, vip_nxt;
  tok_t                 tok_r, tok_nxt;
  logic [CELL_BITS-1:0] mask;
  logic [CELL_BITS-1:0] vip_wait;
  logic [CELL_BITS-1:0] norm_wait;
  logic [CNT_W:0]       lim_e;
  logic                 wr_here;
  logic                 tgt_here;
  logic [CB_W-1:0]      wr_off;
  logic [CB_W-1:0]      tgt_off;

  assign wr_here  = (wr_i.pos[POS_W-1:CB_W] == MY_ID);
  assign wr_off   = wr_i.pos[CB_W-1:0];
  assign tgt_here = (tok_i.target[POS_W-1:CB_W] == MY_ID);
  assign tgt_off  = tok_i.target[CB_W-1:0];
  assign lim_e    = {1'b0, tok_i.limit};

  assign vip_wait  = wait_r & vip_r;
  assign norm_wait = wait_r & ~vip_r;

  always_comb begin
    wait_nxt = wait_r;
    vip_nxt  = vip_r;
    if (wr_i.clr_all) begin
      wait_nxt = '0;
    end else if (wr_here) begin
      if (wr_i.set_en) begin
        wait_nxt[wr_off] = 1'b1;
        vip_nxt[wr_off]  = wr_i.vip;
      end
      if (wr_i.clr_en) begin
        wait_nxt[wr_off] = 1'b0;
      end
    end
  end

  // Only tickets up to and including the limit take part in a count.
  always_comb begin
    if (lim_e >= TOP_E) begin
      mask = '1;
    end else if (lim_e <= BASE_E) begin
      mask = '0;
    end else begin
      for (int j = 0; j < CELL_BITS; j++) begin
        mask[j] = (CB_W'(j) < tok_i.limit[CB_W-1:0]);
      end
    end
  end

  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.valid) begin
      unique case (tok_i.kind)
        SCAN_COUNT: begin
          tok_nxt.cnt = tok_i.cnt + CNT_W'(popcount(wait_r & mask));
        end
        SCAN_CALL: begin
          // Earlier cells hold lower tickets, so the first hit wins.
          if (!tok_i.vip_hit && (|vip_wait)) begin
            tok_nxt.vip_hit = 1'b1;
            tok_nxt.vip_pos = {MY_ID, lowest_set(vip_wait)};
          end
          if (!tok_i.norm_hit && (|norm_wait)) begin
            tok_nxt.norm_hit = 1'b1;
            tok_nxt.norm_pos = {MY_ID, lowest_set(norm_wait)};
          end
        end
        SCAN_CANCEL: begin
          if (tgt_here) begin
            tok_nxt.hit     = wait_r[tgt_off];
            tok_nxt.hit_vip = vip_r[tgt_off];
          end
        end
        default: begin
          tok_nxt = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r      <= '0;
      tok_r.valid <= 1'b0;
    end else begin
      wait_r <= wait_nxt;
      tok_r  <= tok_nxt;
    end
    vip_r <= vip_nxt;
  end

  assign tok_o = tok_r;

endmodule

// ===== src/tctq_checker.sv =====
`include "two_class_ticket_queue_macros.svh"

module tctq_checker import tctq_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [OP_W-1:0]     in_operation,
  input logic                out_valid,
  input logic                out_ready,
  input logic [TICKET_W-1:0] out_ticket,
  input logic                out_is_vip,
  input logic [TICKET_W-1:0] out_tally,
  input logic                out_status
);

  `TCTQ_ASSERT_ALWAYS(a_reset_drops_result, !rst_n |=> !out_valid, "result survived reset")

  `TCTQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_ticket) && $stable(out_is_vip) && $stable(out_tally) && $stable(out_status), "stalled result changed")

  `TCTQ_ASSERT(a_error_is_clean, out_valid && out_status |-> out_ticket == '0 && !out_is_vip && out_tally == '0, "error result carries data")

  `TCTQ_ASSERT(a_vip_is_ticket, out_valid && out_is_vip |-> !out_status && out_tally == '0, "vip flag on a non-ticket result")

  `TCTQ_ASSERT(a_busy_after_op, in_valid && in_ready && in_operation != OP_RESET |=> !in_ready, "accepted a second item while busy")

endmodule

bind two_class_ticket_queue tctq_checker u_tctq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_operation (in_ch.operation),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_ticket   (out_ch.ticket),
  .out_is_vip   (out_ch.is_vip),
  .out_tally    (out_ch.tally),
  .out_status   (out_ch.status)
);
